/* rtl/timestamped_event_queue_dispatch_defines.svh */
// ------------------------------------------------------------------
// Event queue assertion macros
// Shared property wrappers for the event queue checker.
// ------------------------------------------------------------------
`ifndef TIMESTAMPED_EVENT_QUEUE_DISPATCH_DEFINES_SVH
`define TIMESTAMPED_EVENT_QUEUE_DISPATCH_DEFINES_SVH

// same-cycle implication
`define TEQD_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("event queue check failed");

// next-cycle implication
`define TEQD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("event queue check failed");

`endif

/* rtl/teqd_pkg.sv */
// ------------------------------------------------------------------
// Event queue package
// Sizes, stored entry layout and codes for the event queue.
// ------------------------------------------------------------------
package teqd_pkg;

  localparam int CAP   = 32;
  localparam int IDX_W = $clog2(CAP);
  localparam int CNT_W = $clog2(CAP + 1);

  // opcodes
  localparam logic [2:0] OP_SCHEDULE = 3'd0;
  localparam logic [2:0] OP_PROCESS  = 3'd1;
  localparam logic [2:0] OP_PANIC    = 3'd2;
  localparam logic [2:0] OP_CLEAR    = 3'd3;
  localparam logic [2:0] OP_LOCATE   = 3'd4;
  localparam logic [2:0] OP_REWIND   = 3'd5;
  localparam logic [2:0] OP_RESTORE  = 3'd6;
  localparam logic [2:0] OP_NONE     = 3'd7;

  // result status codes
  localparam logic [2:0] ST_ACCEPTED  = 3'd0;
  localparam logic [2:0] ST_QFULL     = 3'd1;
  localparam logic [2:0] ST_INVALID   = 3'd2;
  localparam logic [2:0] ST_AFULL     = 3'd3;
  localparam logic [2:0] ST_DISPATCH  = 3'd4;
  localparam logic [2:0] ST_DONE      = 3'd5;

  // event kinds
  localparam logic [2:0] KIND_NOTEON  = 3'd0;
  localparam logic [2:0] KIND_NOTEOFF = 3'd1;
  localparam logic [2:0] KIND_CC      = 3'd2;
  localparam logic [2:0] KIND_POLYAT  = 3'd3;
  localparam logic [2:0] KIND_BEND    = 3'd4;
  localparam logic [2:0] KIND_CHANAT  = 3'd5;
  localparam logic [2:0] KIND_PARAM   = 3'd6;
  localparam logic [2:0] KIND_ALLOFF  = 3'd7;

  // register indexes
  localparam logic REG_MAX_CHANNEL = 1'b0;
  localparam logic REG_MAX_DATA    = 1'b1;

  localparam logic signed [15:0] Q_ONE  = 16'sd16384;
  localparam logic signed [15:0] Q_MONE = -16'sd16384;
  localparam logic [63:0] FRAME_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

  // one stored event
  typedef struct packed {
    logic [63:0]        frame;
    logic [2:0]         kind;
    logic [15:0]        param;
    logic [7:0]         chan;
    logic [7:0]         data;
    logic signed [15:0] value;
    logic               retain;
  } evt_t;

endpackage

/* rtl/timestamped_event_queue_dispatch.sv */
// ------------------------------------------------------------------
// Timestamped event queue with dispatch
// Frame-sorted pending queue and retained-event archive in RAM.
// ------------------------------------------------------------------
// Usage:
//   Input words (in_valid/in_ready) carry one opcode and its operands.
//   Results leave on out_valid/out_ready; every input word ends with a
//   result whose last_item is set. Process block gives one dispatch
//   result per due event before that final word. Config writes
//   (cfg_valid/cfg_ready, cfg_index, cfg_data) are taken while idle.
// Operation:
//   One input word is worked on at a time; in_ready is high only when
//   the sequencer is idle. Compaction, dispatch and sorted insertion step
//   through a RAM entry by entry (one read, one compare and write);
//   archive rebuild copies entries by sorted insertion. In restore, each
//   transient event may pass every rebuilt one as it is reinserted.
// Reset: counts, transport frame and registers return to their reset
//   values at once; RAM contents are not cleared and no sweep is run.
// Stall: a held result stalls the sequencer at its next result only.
// ------------------------------------------------------------------
module timestamped_event_queue_dispatch (
  input  logic                clk,
  input  logic                rst,
  // input channel
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          opcode,
  input  logic [63:0]         event_frame,
  input  logic [15:0]         block_frames,
  input  logic [63:0]         loop_end_frame,
  input  logic [2:0]          event_kind,
  input  logic [15:0]         param_id,
  input  logic [7:0]          channel_num,
  input  logic [7:0]          data_byte,
  input  logic signed [15:0]  event_value,
  input  logic                retain_flag,
  // result channel
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          status,
  output logic [15:0]         block_offset,
  output logic [63:0]         out_frame,
  output logic [2:0]          out_kind,
  output logic [15:0]         out_param,
  output logic [7:0]          out_channel,
  output logic [7:0]          out_data,
  output logic signed [15:0]  out_value,
  output logic                last_item,
  // config channel
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [7:0]          cfg_data
);

  localparam int CW = teqd_pkg::CNT_W;
  localparam int IW = teqd_pkg::IDX_W;
  localparam logic [CW-1:0] CAP_C = CW'(teqd_pkg::CAP);

  typedef enum logic [4:0] {
    S_IDLE, S_START, S_SCH_CHK, S_SCH_PEND, S_SCH_ARC, S_SCH_OK,
    S_INS_RD, S_INS_CMP, S_CMP_RD, S_CMP_EV,
    S_PR_RD, S_PR_EV, S_PR_END,
    S_RB_RD, S_RB_EV, S_RB_NX,
    S_HD_RD, S_HD_EV, S_RS_RD, S_RS_EV, S_RS_NX, S_DONE
  } state_t;

  typedef enum logic [1:0] {KEEP_NEW, KEEP_RETAIN, KEEP_TAIL} keep_t;

  state_t state, ret;
  keep_t  cmp_mode;

  logic [7:0]        max_channel, max_data;
  logic [2:0]        op;
  teqd_pkg::evt_t    in_ev, ins_e;
  logic [15:0]       frames;
  logic [63:0]       loop_end, lo, hi, pend_end, transport;
  logic [CW-1:0]     pcnt, acnt, idx, kept, nproc, nh, pos, cmp_lim;
  logic              ins_arc, cmp_arc, rb_restore;
  logic [2:0]        st;

  // RAMs and their ports
  teqd_pkg::evt_t pend_mem [teqd_pkg::CAP];
  teqd_pkg::evt_t arc_mem  [teqd_pkg::CAP];
  teqd_pkg::evt_t held_mem [teqd_pkg::CAP];
  teqd_pkg::evt_t p_rd, a_rd, h_rd;
  logic [IW-1:0]  p_raddr, a_raddr, h_raddr, t_waddr, h_waddr;
  logic           p_we, a_we, h_we;
  teqd_pkg::evt_t t_wdata;

  teqd_pkg::evt_t ins_rd, cmp_rd;
  logic           ins_gt, keep, ev_ok, slot_free, pr_due;
  logic [64:0]    end_sum;
  logic [63:0]    pr_diff;
  logic [CW-1:0]  pos_m1;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;

  assign pos_m1 = pos - CW'(1);
  assign ins_rd = ins_arc ? a_rd : p_rd;
  assign cmp_rd = cmp_arc ? a_rd : p_rd;
  assign ins_gt = ins_rd.frame > ins_e.frame;

  // keep test for compaction passes
  always_comb begin
    case (cmp_mode)
      KEEP_NEW:    keep = cmp_rd.frame >= transport;
      KEEP_RETAIN: keep = cmp_rd.retain;
      KEEP_TAIL:   keep = idx >= nproc;
      default:     keep = 1'b0;
    endcase
  end

  // event validity against the limit registers
  always_comb begin
    logic norm;
    norm = (in_ev.value >= 16'sd0) && (in_ev.value <= teqd_pkg::Q_ONE);
    if (in_ev.chan > max_channel) begin
      ev_ok = 1'b0;
    end else if (in_ev.kind == teqd_pkg::KIND_BEND) begin
      ev_ok = (in_ev.value >= teqd_pkg::Q_MONE) && (in_ev.value <= teqd_pkg::Q_ONE);
    end else if (in_ev.kind == teqd_pkg::KIND_CHANAT) begin
      ev_ok = norm;
    end else if (in_ev.kind >= teqd_pkg::KIND_PARAM) begin
      ev_ok = 1'b1;
    end else begin
      ev_ok = (in_ev.data <= max_data) && norm;
    end
  end

  // block end with saturation, dispatch test and offset
  assign end_sum = {1'b0, transport} + {49'd0, frames};
  assign pr_due  = (p_rd.frame <= transport) || (p_rd.frame < pend_end);
  assign pr_diff = p_rd.frame - transport;

  // RAM address and write selection
  always_comb begin
    p_raddr = (state == S_INS_RD) ? pos_m1[IW-1:0] : idx[IW-1:0];
    a_raddr = p_raddr;
    h_raddr = idx[IW-1:0];
    p_we    = 1'b0;
    a_we    = 1'b0;
    h_we    = 1'b0;
    t_waddr = pos[IW-1:0];
    t_wdata = ins_e;
    h_waddr = nh[IW-1:0];
    case (state)
      S_INS_RD: begin
        if (pos == '0) begin
          p_we = !ins_arc;
          a_we = ins_arc;
        end
      end
      S_INS_CMP: begin
        p_we    = !ins_arc;
        a_we    = ins_arc;
        t_wdata = ins_gt ? ins_rd : ins_e;
      end
      S_CMP_EV: begin
        p_we    = keep && !cmp_arc;
        a_we    = keep && cmp_arc;
        t_waddr = kept[IW-1:0];
        t_wdata = cmp_rd;
      end
      S_HD_EV: begin
        h_we = !p_rd.retain;
      end
      default: begin
      end
    endcase
  end

  // pending queue RAM
  always_ff @(posedge clk) begin
    if (p_we) pend_mem[t_waddr] <= t_wdata;
    p_rd <= pend_mem[p_raddr];
  end

  // archive RAM
  always_ff @(posedge clk) begin
    if (a_we) arc_mem[t_waddr] <= t_wdata;
    a_rd <= arc_mem[a_raddr];
  end

  // scratch RAM for transient events across restore
  always_ff @(posedge clk) begin
    if (h_we) held_mem[h_waddr] <= p_rd;
    h_rd <= held_mem[h_raddr];
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      ret         <= S_IDLE;
      max_channel <= 8'd15;
      max_data    <= 8'd127;
      pcnt        <= '0;
      acnt        <= '0;
      transport   <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == teqd_pkg::REG_MAX_CHANNEL) max_channel <= cfg_data;
        if (cfg_index == teqd_pkg::REG_MAX_DATA)    max_data    <= cfg_data;
      end
      if (out_valid && out_ready) out_valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op       <= opcode;
            in_ev    <= '{event_frame, event_kind, param_id, channel_num,
                          data_byte, event_value, retain_flag};
            frames   <= block_frames;
            loop_end <= loop_end_frame;
            state    <= S_START;
          end
        end

        S_START: begin
          st  <= teqd_pkg::ST_DONE;
          idx <= '0;
          case (op)
            teqd_pkg::OP_SCHEDULE: begin
              if (pcnt >= CAP_C) begin
                st <= teqd_pkg::ST_QFULL;  state <= S_DONE;
              end else if (!ev_ok) begin
                st <= teqd_pkg::ST_INVALID; state <= S_DONE;
              end else if (in_ev.retain && acnt >= CAP_C) begin
                cmp_arc <= 1'b1; cmp_mode <= KEEP_NEW; cmp_lim <= acnt;
                kept <= '0; ret <= S_SCH_CHK; state <= S_CMP_RD;
              end else begin
                state <= S_SCH_PEND;
              end
            end
            teqd_pkg::OP_PROCESS: begin
              if (frames == 16'd0) begin
                state <= S_DONE;
              end else begin
                pend_end <= end_sum[64] ? teqd_pkg::FRAME_MAX : end_sum[63:0];
                state    <= S_PR_RD;
              end
            end
            teqd_pkg::OP_PANIC: begin
              cmp_arc <= 1'b0; cmp_mode <= KEEP_RETAIN; cmp_lim <= pcnt;
              kept <= '0; ret <= S_DONE; state <= S_CMP_RD;
            end
            teqd_pkg::OP_CLEAR: begin
              pcnt <= '0; acnt <= '0; state <= S_DONE;
            end
            teqd_pkg::OP_LOCATE: begin
              pcnt <= '0; acnt <= '0; transport <= in_ev.frame; state <= S_DONE;
            end
            teqd_pkg::OP_REWIND: begin
              transport  <= in_ev.frame;
              lo         <= in_ev.frame;
              hi         <= loop_end;
              pcnt       <= '0;
              rb_restore <= 1'b0;
              state      <= S_RB_RD;
            end
            teqd_pkg::OP_RESTORE: begin
              nh <= '0; state <= S_HD_RD;
            end
            default: state <= S_DONE;
          endcase
        end

        // schedule steps
        S_SCH_CHK: begin
          if (acnt == cmp_lim) begin
            st <= teqd_pkg::ST_AFULL; state <= S_DONE;
          end else begin
            state <= S_SCH_PEND;
          end
        end
        S_SCH_PEND: begin
          ins_e <= in_ev; ins_arc <= 1'b0; pos <= pcnt;
          ret   <= in_ev.retain ? S_SCH_ARC : S_SCH_OK;
          state <= S_INS_RD;
        end
        S_SCH_ARC: begin
          ins_e <= in_ev; ins_arc <= 1'b1; pos <= acnt;
          ret <= S_SCH_OK; state <= S_INS_RD;
        end
        S_SCH_OK: begin
          st <= teqd_pkg::ST_ACCEPTED; state <= S_DONE;
        end

        // sorted insertion, walking down from the tail
        S_INS_RD: begin
          if (pos == '0) begin
            if (ins_arc) acnt <= acnt + CW'(1);
            else         pcnt <= pcnt + CW'(1);
            state <= ret;
          end else begin
            state <= S_INS_CMP;
          end
        end
        S_INS_CMP: begin
          if (ins_gt) begin
            pos   <= pos_m1;
            state <= S_INS_RD;
          end else begin
            if (ins_arc) acnt <= acnt + CW'(1);
            else         pcnt <= pcnt + CW'(1);
            state <= ret;
          end
        end

        // in-place compaction
        S_CMP_RD: begin
          if (idx == cmp_lim) begin
            if (cmp_arc) acnt <= kept;
            else         pcnt <= kept;
            state <= ret;
          end else begin
            state <= S_CMP_EV;
          end
        end
        S_CMP_EV: begin
          if (keep) kept <= kept + CW'(1);
          idx   <= idx + CW'(1);
          state <= S_CMP_RD;
        end

        // dispatch of due events
        S_PR_RD: begin
          state <= (idx == pcnt) ? S_PR_END : S_PR_EV;
        end
        S_PR_EV: begin
          if (!pr_due) begin
            state <= S_PR_END;
          end else if (slot_free) begin
            out_valid    <= 1'b1;
            status       <= teqd_pkg::ST_DISPATCH;
            block_offset <= (p_rd.frame <= transport) ? 16'd0 : pr_diff[15:0];
            out_frame    <= p_rd.frame;
            out_kind     <= p_rd.kind;
            out_param    <= p_rd.param;
            out_channel  <= p_rd.chan;
            out_data     <= p_rd.data;
            out_value    <= p_rd.value;
            last_item    <= 1'b0;
            idx          <= idx + CW'(1);
            state        <= S_PR_RD;
          end
        end
        S_PR_END: begin
          transport <= pend_end;
          nproc     <= idx;
          idx       <= '0;
          if (idx == '0) begin
            state <= S_DONE;
          end else begin
            cmp_arc <= 1'b0; cmp_mode <= KEEP_TAIL; cmp_lim <= pcnt;
            kept <= '0; ret <= S_DONE; state <= S_CMP_RD;
          end
        end

        // rebuild pending queue from the archive
        S_RB_RD: begin
          if (idx == acnt) begin
            idx   <= '0;
            state <= rb_restore ? S_RS_RD : S_DONE;
          end else begin
            state <= S_RB_EV;
          end
        end
        S_RB_EV: begin
          if (a_rd.frame >= lo && a_rd.frame < hi && pcnt < CAP_C) begin
            ins_e <= a_rd; ins_arc <= 1'b0; pos <= pcnt;
            ret <= S_RB_NX; state <= S_INS_RD;
          end else begin
            idx <= idx + CW'(1); state <= S_RB_RD;
          end
        end
        S_RB_NX: begin
          idx <= idx + CW'(1); state <= S_RB_RD;
        end

        // restore: park transient events, rebuild, then reinsert
        S_HD_RD: begin
          if (idx == pcnt) begin
            lo <= in_ev.frame; hi <= teqd_pkg::FRAME_MAX;
            pcnt <= '0; idx <= '0; rb_restore <= 1'b1;
            state <= S_RB_RD;
          end else begin
            state <= S_HD_EV;
          end
        end
        S_HD_EV: begin
          if (!p_rd.retain) nh <= nh + CW'(1);
          idx <= idx + CW'(1); state <= S_HD_RD;
        end
        S_RS_RD: begin
          state <= (idx == nh || pcnt >= CAP_C) ? S_DONE : S_RS_EV;
        end
        S_RS_EV: begin
          ins_e <= h_rd; ins_arc <= 1'b0; pos <= pcnt;
          ret <= S_RS_NX; state <= S_INS_RD;
        end
        S_RS_NX: begin
          idx <= idx + CW'(1); state <= S_RS_RD;
        end

        // final word of the input
        S_DONE: begin
          if (slot_free) begin
            out_valid    <= 1'b1;
            status       <= st;
            block_offset <= '0;
            out_frame    <= '0;
            out_kind     <= '0;
            out_param    <= '0;
            out_channel  <= '0;
            out_data     <= '0;
            out_value    <= '0;
            last_item    <= 1'b1;
            state        <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/teqd_checker.sv */
// ------------------------------------------------------------------
// Event queue port checker
// Watches the top-level ports of the event queue over time.
// ------------------------------------------------------------------
`include "timestamped_event_queue_dispatch_defines.svh"

module teqd_port_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] status,
  input logic       last_item
);

  // a held result word stays put
  `TEQD_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  `TEQD_ASSERT_NEXT(a_status_hold, clk, rst, out_valid && !out_ready, $stable(status))

  // only dispatch words may leave last_item low
  `TEQD_ASSERT_NOW(a_last_dispatch, clk, rst,
    out_valid && !last_item, status == teqd_pkg::ST_DISPATCH)

  // one word in work at a time
  `TEQD_ASSERT_NEXT(a_busy_after_take, clk, rst, in_valid && in_ready, !in_ready)

endmodule

bind timestamped_event_queue_dispatch teqd_port_checker u_teqd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .status    (status),
  .last_item (last_item)
);

/* tb/teqd_checker.sv */
// ------------------------------------------------------------------
// Event queue result checker
// Watches the input, result and register channels, keeps its own model
// of the pending queue, archive and transport frame, predicts every
// result word and compares each accepted result field by field.
// ------------------------------------------------------------------
module teqd_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [2:0]         opcode,
  input  logic [63:0]        event_frame,
  input  logic [15:0]        block_frames,
  input  logic [63:0]        loop_end_frame,
  input  logic [2:0]         event_kind,
  input  logic [15:0]        param_id,
  input  logic [7:0]         channel_num,
  input  logic [7:0]         data_byte,
  input  logic signed [15:0] event_value,
  input  logic               retain_flag,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [2:0]         status,
  input  logic [15:0]        block_offset,
  input  logic [63:0]        out_frame,
  input  logic [2:0]         out_kind,
  input  logic [15:0]        out_param,
  input  logic [7:0]         out_channel,
  input  logic [7:0]         out_data,
  input  logic signed [15:0] out_value,
  input  logic               last_item,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [7:0]         cfg_data,
  output int                 fail_count,
  output int                 pending_words,
  output int                 dispatch_seen,
  output int                 reject_seen
);

  typedef struct packed {
    logic [2:0]         st;
    logic [15:0]        offs;
    logic [63:0]        frame;
    logic [2:0]         kind;
    logic [15:0]        param;
    logic [7:0]         chan;
    logic [7:0]         data;
    logic signed [15:0] value;
    logic               last;
  } result_t;

  result_t expected_q[$];
  teqd_pkg::evt_t queue_m[$];
  teqd_pkg::evt_t archive_m[$];
  logic [63:0] transport_m;
  logic [7:0] lim_chan, lim_data;

  assign pending_words = expected_q.size();

  // frame-sorted insert, equal frames keep arrival order
  function automatic void put_sorted(ref teqd_pkg::evt_t arr[$], input teqd_pkg::evt_t e);
    int pos;
    pos = arr.size();
    if (pos >= teqd_pkg::CAP) return;
    while (pos > 0 && arr[pos-1].frame > e.frame) pos--;
    arr.insert(pos, e);
  endfunction

  function automatic bit event_ok(teqd_pkg::evt_t e);
    bit norm;
    norm = e.value >= 16'sd0 && e.value <= teqd_pkg::Q_ONE;
    if (e.chan > lim_chan) return 0;
    if (e.kind < teqd_pkg::KIND_BEND) return e.data <= lim_data && norm;
    if (e.kind == teqd_pkg::KIND_BEND)
      return e.value >= teqd_pkg::Q_MONE && e.value <= teqd_pkg::Q_ONE;
    if (e.kind == teqd_pkg::KIND_CHANAT) return norm;
    return 1;
  endfunction

  function automatic void rebuild(logic [63:0] lo, logic [63:0] hi);
    queue_m.delete();
    foreach (archive_m[i])
      if (archive_m[i].frame >= lo && archive_m[i].frame < hi)
        put_sorted(queue_m, archive_m[i]);
  endfunction

  function automatic void push_status(logic [2:0] st);
    result_t r;
    r = '0;
    r.st = st;
    r.last = 1'b1;
    expected_q.push_back(r);
  endfunction

  function automatic logic [2:0] schedule_event(teqd_pkg::evt_t e);
    int old_n;
    teqd_pkg::evt_t kept[$];
    if (queue_m.size() >= teqd_pkg::CAP) return teqd_pkg::ST_QFULL;
    if (!event_ok(e)) return teqd_pkg::ST_INVALID;
    if (e.retain && archive_m.size() >= teqd_pkg::CAP) begin
      old_n = 0;
      foreach (archive_m[i]) if (archive_m[i].frame < transport_m) old_n++;
      if (old_n == 0) return teqd_pkg::ST_AFULL;
      foreach (archive_m[i])
        if (archive_m[i].frame >= transport_m) kept.push_back(archive_m[i]);
      archive_m = kept;
    end
    put_sorted(queue_m, e);
    if (e.retain) put_sorted(archive_m, e);
    return teqd_pkg::ST_ACCEPTED;
  endfunction

  function automatic void process_block(logic [15:0] frames);
    logic [63:0] start, stop, off, nf;
    result_t r;
    teqd_pkg::evt_t e;
    if (frames == 16'd0) return;
    nf = {48'd0, frames};
    start = transport_m;
    stop = (nf > teqd_pkg::FRAME_MAX - start) ? teqd_pkg::FRAME_MAX : start + nf;
    while (queue_m.size() > 0) begin
      e = queue_m[0];
      if (!(e.frame <= start || e.frame < stop)) break;
      off = (e.frame <= start) ? 64'd0 : e.frame - start;
      if (off > nf) off = nf;
      r = '0;
      r.st = teqd_pkg::ST_DISPATCH;
      r.offs = off[15:0];
      r.frame = e.frame;
      r.kind = e.kind;
      r.param = e.param;
      r.chan = e.chan;
      r.data = e.data;
      r.value = e.value;
      expected_q.push_back(r);
      void'(queue_m.pop_front());
    end
    transport_m = stop;
  endfunction

  // work out the result words of one accepted input word
  function automatic void predict_word(logic [2:0] op, teqd_pkg::evt_t e,
                                       logic [15:0] frames, logic [63:0] loop_end);
    teqd_pkg::evt_t held[$];
    teqd_pkg::evt_t kept[$];
    logic [2:0] st;
    case (op)
      teqd_pkg::OP_SCHEDULE: begin
        st = schedule_event(e);
        if (st != teqd_pkg::ST_ACCEPTED) reject_seen++;
        push_status(st);
        return;
      end
      teqd_pkg::OP_PROCESS: process_block(frames);
      teqd_pkg::OP_PANIC: begin
        foreach (queue_m[i]) if (queue_m[i].retain) kept.push_back(queue_m[i]);
        queue_m = kept;
      end
      teqd_pkg::OP_CLEAR: begin
        queue_m.delete();
        archive_m.delete();
      end
      teqd_pkg::OP_LOCATE: begin
        queue_m.delete();
        archive_m.delete();
        transport_m = e.frame;
      end
      teqd_pkg::OP_REWIND: begin
        transport_m = e.frame;
        rebuild(e.frame, loop_end);
      end
      teqd_pkg::OP_RESTORE: begin
        foreach (queue_m[i]) if (!queue_m[i].retain) held.push_back(queue_m[i]);
        rebuild(e.frame, teqd_pkg::FRAME_MAX);
        foreach (held[i])
          if (queue_m.size() < teqd_pkg::CAP) put_sorted(queue_m, held[i]);
      end
      default: ;
    endcase
    push_status(teqd_pkg::ST_DONE);
  endfunction

  always @(posedge clk) begin
    teqd_pkg::evt_t e;
    result_t got, want;
    if (rst) begin
      queue_m.delete();
      archive_m.delete();
      expected_q.delete();
      transport_m = '0;
      lim_chan = 8'd15;
      lim_data = 8'd127;
      fail_count = 0;
      dispatch_seen = 0;
      reject_seen = 0;
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == teqd_pkg::REG_MAX_CHANNEL) lim_chan = cfg_data;
        else lim_data = cfg_data;
      end
      // result word against the oldest expectation
      if (out_valid && out_ready) begin
        got = {status, block_offset, out_frame, out_kind, out_param, out_channel,
               out_data, out_value, last_item};
        if (expected_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result word %h", $time, got);
        end else begin
          want = expected_q.pop_front();
          if (got.st == teqd_pkg::ST_DISPATCH) dispatch_seen++;
          if (got !== want) begin
            fail_count++;
            $display("%0t: mismatch exp st=%0d off=%0d fr=%h k=%0d p=%h c=%0d d=%0d",
                     $time, want.st, want.offs, want.frame, want.kind, want.param,
                     want.chan, want.data);
            $display("%0t:          exp v=%0d l=%0b", $time, want.value, want.last);
            $display("%0t:          got st=%0d off=%0d fr=%h k=%0d p=%h c=%0d d=%0d",
                     $time, got.st, got.offs, got.frame, got.kind, got.param,
                     got.chan, got.data);
            $display("%0t:          got v=%0d l=%0b", $time, got.value, got.last);
          end
        end
      end
      // input word
      if (in_valid && in_ready) begin
        e.frame = event_frame;
        e.kind = event_kind;
        e.param = param_id;
        e.chan = channel_num;
        e.data = data_byte;
        e.value = event_value;
        e.retain = retain_flag;
        predict_word(opcode, e, block_frames, loop_end_frame);
      end
    end
  end

endmodule

/* tb/tb.sv */
// ------------------------------------------------------------------
// Event queue testbench
// Drives directed and random opcode sequences through the event queue
// under several idling phases and register settings; a checker module
// predicts and compares every result word.
// ------------------------------------------------------------------
module tb;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [2:0] opcode, event_kind, status, out_kind;
  logic [63:0] event_frame, loop_end_frame, out_frame;
  logic [15:0] block_frames, param_id, block_offset, out_param;
  logic [7:0] channel_num, data_byte, out_channel, out_data, cfg_data;
  logic signed [15:0] event_value, out_value;
  logic retain_flag, last_item, cfg_valid, cfg_ready, cfg_index;
  int fail_count, pending_words, dispatch_seen, reject_seen;
  int send_idle, recv_stall, words_sent, cycle_count;
  logic [63:0] base_frame;

  timestamped_event_queue_dispatch dut (.*);
  teqd_checker chk (.*);

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  // watchdog
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 1500000) begin
        $display("** timestamped_event_queue_dispatch: FAILED **");
        $finish;
      end
    end
  end

  // receiver stalls
  always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_stall);

  // valid stays up after a word is taken until the next word or a pause
  task automatic send_word(logic [2:0] op, logic [63:0] fr, logic [15:0] nf,
                           logic [63:0] le, logic [2:0] k, logic [15:0] p,
                           logic [7:0] c, logic [7:0] d, logic [15:0] v, logic r);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    opcode <= op; event_frame <= fr; block_frames <= nf; loop_end_frame <= le;
    event_kind <= k; param_id <= p; channel_num <= c; data_byte <= d;
    event_value <= v; retain_flag <= r; in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
    @(negedge clk);
  endtask

  // control word, event fields filled with noise
  task automatic send_ctl(logic [2:0] op, logic [63:0] fr, logic [15:0] nf,
                          logic [63:0] le);
    send_word(op, fr, nf, le, 3'($urandom), 16'($urandom), 8'($urandom),
              8'($urandom), 16'($urandom), 1'($urandom));
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_words != 0) @(negedge clk);
    repeat (220) @(negedge clk);
  endtask

  // both limit registers, back to back
  task automatic write_limits(logic [7:0] chan_lim, logic [7:0] data_lim);
    cfg_index <= teqd_pkg::REG_MAX_CHANNEL; cfg_data <= chan_lim; cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_index <= teqd_pkg::REG_MAX_DATA; cfg_data <= data_lim;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // one schedule with mostly legal content near the transport frame
  task automatic rand_schedule();
    logic [2:0] k;
    logic [15:0] v;
    logic [7:0] c, d;
    k = 3'($urandom_range(7));
    v = (k == teqd_pkg::KIND_BEND) ? 16'($signed($urandom_range(32768)) - 16384)
                                   : 16'($urandom_range(16384));
    if ($urandom_range(9) == 0) v = 16'($urandom);
    c = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(15));
    d = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(127));
    send_word(teqd_pkg::OP_SCHEDULE, base_frame + 64'($urandom_range(300)),
              16'($urandom), 64'($urandom), k, 16'($urandom), c, d, v,
              1'($urandom_range(1)));
  endtask

  task automatic rand_phase(int n);
    int sel;
    repeat (n) begin
      sel = $urandom_range(99);
      if (sel < 60) rand_schedule();
      else if (sel < 80) begin
        send_ctl(teqd_pkg::OP_PROCESS, 64'($urandom),
                 ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(120)),
                 64'($urandom));
        base_frame += 64'd60;
      end else if (sel < 84) send_ctl(teqd_pkg::OP_PANIC, 64'($urandom), 16'($urandom),
                                      64'($urandom));
      else if (sel < 86) send_ctl(teqd_pkg::OP_CLEAR, 64'($urandom), 16'($urandom),
                                  64'($urandom));
      else if (sel < 88) begin
        base_frame = 64'($urandom_range(1000));
        send_ctl(teqd_pkg::OP_LOCATE, base_frame, 16'($urandom), 64'($urandom));
      end else if (sel < 93) send_ctl(teqd_pkg::OP_REWIND,
                                      base_frame - 64'($urandom_range(200)), 16'($urandom),
                                      base_frame + 64'($urandom_range(300)));
      else if (sel < 98) send_ctl(teqd_pkg::OP_RESTORE,
                                  base_frame - 64'($urandom_range(200)), 16'($urandom),
                                  64'($urandom));
      else send_ctl(teqd_pkg::OP_NONE, 64'($urandom), 16'($urandom), 64'($urandom));
    end
  endtask

  initial begin
    rst = 1'b1; in_valid = 1'b0; cfg_valid = 1'b0; cfg_index = 1'b0; cfg_data = '0;
    opcode = '0; event_frame = '0; block_frames = '0; loop_end_frame = '0;
    event_kind = '0; param_id = '0; channel_num = '0; data_byte = '0;
    event_value = '0; retain_flag = 1'b0; out_ready = 1'b1;
    send_idle = 0; recv_stall = 0; words_sent = 0; base_frame = 64'd100;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: validity edges, every opcode, saturation
    send_word(teqd_pkg::OP_SCHEDULE, 64'd100, 16'd0, 64'd0, teqd_pkg::KIND_NOTEON,
              16'h0, 8'd15, 8'd127, teqd_pkg::Q_ONE, 1'b1);
    send_word(teqd_pkg::OP_SCHEDULE, 64'd100, 16'd0, 64'd0, teqd_pkg::KIND_NOTEOFF,
              16'hFFFF, 8'd16, 8'd0, 16'd0, 1'b0);
    send_word(teqd_pkg::OP_SCHEDULE, 64'd90, 16'd0, 64'd0, teqd_pkg::KIND_CC,
              16'h0, 8'd0, 8'd128, 16'd0, 1'b0);
    send_word(teqd_pkg::OP_SCHEDULE, 64'd90, 16'd0, 64'd0, teqd_pkg::KIND_POLYAT,
              16'h0, 8'd0, 8'd0, 16'd16385, 1'b0);
    send_word(teqd_pkg::OP_SCHEDULE, 64'd120, 16'd0, 64'd0, teqd_pkg::KIND_BEND,
              16'h0, 8'd1, 8'd255, teqd_pkg::Q_MONE, 1'b1);
    send_word(teqd_pkg::OP_SCHEDULE, 64'd120, 16'd0, 64'd0, teqd_pkg::KIND_BEND,
              16'h0, 8'd1, 8'd0, 16'h8000, 1'b0);
    send_word(teqd_pkg::OP_SCHEDULE, 64'd130, 16'd0, 64'd0, teqd_pkg::KIND_CHANAT,
              16'h0, 8'd2, 8'd0, 16'hFFFF, 1'b0);
    send_word(teqd_pkg::OP_SCHEDULE, 64'd50, 16'd0, 64'd0, teqd_pkg::KIND_PARAM,
              16'hFFFF, 8'd3, 8'd255, 16'h7FFF, 1'b0);
    send_word(teqd_pkg::OP_SCHEDULE, 64'd110, 16'd0, 64'd0, teqd_pkg::KIND_ALLOFF,
              16'h0, 8'd4, 8'd0, 16'h8000, 1'b1);
    send_ctl(teqd_pkg::OP_PROCESS, 64'd0, 16'd0, 64'd0);
    send_ctl(teqd_pkg::OP_PROCESS, 64'd0, 16'd115, 64'd0);
    send_ctl(teqd_pkg::OP_REWIND, 64'd100, 16'd0, 64'd125);
    send_ctl(teqd_pkg::OP_PANIC, 64'd0, 16'd0, 64'd0);
    send_ctl(teqd_pkg::OP_RESTORE, 64'd0, 16'd0, 64'd0);
    send_ctl(teqd_pkg::OP_PROCESS, 64'd0, 16'hFFFF, 64'd0);
    send_ctl(teqd_pkg::OP_LOCATE, 64'hFFFF_FFFF_FFFF_FFF0, 16'd0, 64'd0);
    send_word(teqd_pkg::OP_SCHEDULE, teqd_pkg::FRAME_MAX, 16'd0, 64'd0, teqd_pkg::KIND_CC,
              16'h0, 8'd0, 8'd0, 16'd5, 1'b1);
    send_ctl(teqd_pkg::OP_PROCESS, 64'd0, 16'hFFFF, 64'd0);
    send_ctl(teqd_pkg::OP_NONE, 64'd0, 16'd0, 64'd0);
    send_ctl(teqd_pkg::OP_CLEAR, 64'd0, 16'd0, 64'd0);
    send_ctl(teqd_pkg::OP_LOCATE, 64'd100, 16'd0, 64'd0);
    // pause until everything has come out
    wait_drain();

    // fill the archive with retained events, then force compaction
    base_frame = 64'd100;
    repeat (34) begin
      send_word(teqd_pkg::OP_SCHEDULE, 64'(100 + $urandom_range(50)), 16'd0, 64'd0,
                teqd_pkg::KIND_PARAM, 16'($urandom), 8'd0, 8'd0, 16'($urandom), 1'b1);
    end
    send_ctl(teqd_pkg::OP_PROCESS, 64'd0, 16'd200, 64'd0);
    base_frame = 64'd300;
    repeat (3) rand_schedule();
    wait_drain();

    // register extremes and random phases
    write_limits(8'd0, 8'd0);
    send_idle = 0; recv_stall = 0; rand_phase(45); wait_drain();
    write_limits(8'd255, 8'd255);
    send_idle = 50; recv_stall = 0; rand_phase(45); wait_drain();
    write_limits(8'd15, 8'd127);
    send_idle = 0; recv_stall = 50; rand_phase(45); wait_drain();
    write_limits(8'd7, 8'd64);
    send_idle = 8; recv_stall = 8; rand_phase(45); wait_drain();

    $display("Sent %0d input words over four idling phases and four register settings;",
             words_sent);
    $display("saw %0d dispatched events and %0d rejected schedules.",
             dispatch_seen, reject_seen);
    if (fail_count == 0) $display("** timestamped_event_queue_dispatch: PASSED **");
    else $display("** timestamped_event_queue_dispatch: FAILED **");
    $finish;
  end

endmodule
